>>> rtl/core/spnp_pkg.sv
// Package for the sphere-point to nested-pixel mapper.
// Holds the fixed-point constants, field widths and the side-band struct
// shared by the front end, the square-root pipeline and the back end.
`default_nettype none

package spnp_pkg;

   // Field widths of the ports.
   localparam int unsigned ORDER_W = 4;
   localparam int unsigned PIX_W   = 30;
   localparam int unsigned FACE_W  = 4;

   // In-face edge indices are carried at the widest order the grid supports.
   localparam int unsigned EDGE_W  = 15;

   // Default for the highest resolution order.
   localparam int unsigned MAX_ORDER_DEFAULT = 13;

   // Fixed-point constants.
   localparam logic [30:0] TWO_PI_Q28      = 31'd1686629713;
   localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261102;
   localparam logic [30:0] TWO_THIRDS_Q30  = 31'd715827882;
   localparam logic [30:0] ONE_Q30         = 31'd1073741824;
   localparam logic [34:0] HALF_Q32        = 35'd2147483648;

   // Per-item side information that travels alongside the square root.
   typedef struct packed {
      logic              belt;      // point lies in the equatorial belt
      logic              north;     // z is non-negative
      logic [FACE_W-1:0] face;      // belt face
      logic [EDGE_W-1:0] ix;        // belt in-face x
      logic [EDGE_W-1:0] iy;        // belt in-face y
      logic [1:0]        ntt;       // polar sector
      logic [31:0]       tp;        // fractional part of the sector coordinate
   } spnp_side_type;

endpackage : spnp_pkg

`default_nettype wire

>>> rtl/core/spnp_front.sv
// Front end of the mapper: longitude reduction, scaling to sector units,
// the belt edge-line indices and the radicand for the polar caps.
// Depends on spnp_pkg.
`default_nettype none

module spnp_front
   import spnp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [ORDER_W-1:0] order,
   input  wire logic               in_valid,
   input  wire logic signed [31:0] z_cos_theta,
   input  wire logic signed [31:0] phi_radians,
   output logic                    out_valid,
   output logic [63:0]             radicand,
   output spnp_side_type           side
);

   // Stage 1: |z| saturated to one, phi reduced into [0, 2pi).
   logic signed [32:0] z_ext;
   logic signed [32:0] za_full;
   logic [30:0]        za1_in;
   logic signed [33:0] p0, p_minus, p_plus, p_plus2;
   logic [30:0]        p1_in;

   logic               s1_valid_ff;
   logic [30:0]        s1_za_ff;
   logic               s1_neg_ff;
   logic [30:0]        s1_p_ff;

   always_comb begin
      z_ext   = {z_cos_theta[31], z_cos_theta};
      za_full = z_cos_theta[31] ? -z_ext : z_ext;
      za1_in  = (za_full > $signed({2'b00, ONE_Q30})) ? ONE_Q30 : za_full[30:0];
      p0      = {{2{phi_radians[31]}}, phi_radians};
      p_minus = p0 - $signed({3'b000, TWO_PI_Q28});
      p_plus  = p0 + $signed({3'b000, TWO_PI_Q28});
      p_plus2 = p_plus + $signed({3'b000, TWO_PI_Q28});
      if (p0 < 0) begin
         p1_in = (p_plus < 0) ? p_plus2[30:0] : p_plus[30:0];
      end else begin
         p1_in = (p_minus >= 0) ? p_minus[30:0] : p0[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      s1_za_ff  <= za1_in;
      s1_neg_ff <= z_cos_theta[31];
      s1_p_ff   <= p1_in;
   end

   // Stage 2: scale phi by 2/pi, form 3z for the belt and 3(1-|z|) for the caps.
   logic [62:0]        prod2;
   logic [33:0]        tt2_in;
   logic signed [31:0] zsat;
   logic signed [33:0] zs2_in;
   logic [30:0]        d2;
   logic [32:0]        d3_2;

   logic               s2_valid_ff;
   logic [33:0]        s2_tt_ff;
   logic               s2_belt_ff;
   logic               s2_neg_ff;
   logic signed [33:0] s2_zs_ff;
   logic [29:0]        s2_d3_ff;

   always_comb begin
      prod2  = s1_p_ff * TWO_OVER_PI_Q32;
      tt2_in = prod2[61:28];
      zsat   = s1_neg_ff ? -$signed({1'b0, s1_za_ff}) : $signed({1'b0, s1_za_ff});
      zs2_in = ($signed({{2{zsat[31]}}, zsat}) <<< 1) + $signed({{2{zsat[31]}}, zsat});
      d2     = ONE_Q30 - s1_za_ff;
      d3_2   = ({2'b00, d2} << 1) + {2'b00, d2};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_tt_ff   <= tt2_in;
      s2_belt_ff <= (s1_za_ff <= TWO_THIRDS_Q30);
      s2_neg_ff  <= s1_neg_ff;
      s2_zs_ff   <= zs2_in;
      s2_d3_ff   <= d3_2[29:0];
   end

   // Stage 3: belt edge lines, face and in-face indices; polar sector split.
   logic signed [35:0] a36, zs36, sm, sp;
   logic [2:0]         ifp, ifm;
   logic [FACE_W-1:0]  face3;
   logic [EDGE_W-1:0]  mask3, jp_low, jm_low;
   logic [ORDER_W-1:0] drop3;
   spnp_side_type      side3_in;

   always_comb begin
      a36    = $signed({1'b0, HALF_Q32 + {1'b0, s2_tt_ff}});
      zs36   = {{2{s2_zs_ff[33]}}, s2_zs_ff};
      sm     = a36 - zs36;
      sp     = a36 + zs36;
      ifp    = sm[34:32];
      ifm    = sp[34:32];
      drop3  = ORDER_W'(EDGE_W) - order;
      mask3  = (EDGE_W'(1) << order) - EDGE_W'(1);
      jp_low = sm[31 -: EDGE_W] >> drop3;
      jm_low = sp[31 -: EDGE_W] >> drop3;
      if (ifp == ifm) begin
         face3 = (ifp == 3'd4) ? FACE_W'(4) : FACE_W'(ifp) + FACE_W'(4);
      end else if (ifp < ifm) begin
         face3 = FACE_W'(ifp);
      end else begin
         face3 = FACE_W'(ifm) + FACE_W'(8);
      end
      side3_in.belt  = s2_belt_ff;
      side3_in.north = !s2_neg_ff;
      side3_in.face  = face3;
      side3_in.ix    = jm_low;
      side3_in.iy    = jp_low ^ mask3;
      side3_in.ntt   = s2_tt_ff[33:32];
      side3_in.tp    = s2_tt_ff[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else begin
         out_valid <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      side     <= side3_in;
      radicand <= {s2_d3_ff, 34'd0};
   end

endmodule : spnp_front

`default_nettype wire

>>> rtl/core/spnp_isqrt.sv
// Pipelined integer square root of a 64-bit radicand, two result bits
// per stage, with the item's side information carried alongside.
// Depends on spnp_pkg.
`default_nettype none

module spnp_isqrt
   import spnp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire logic [63:0]   radicand,
   input  spnp_side_type      side_in,
   output logic               out_valid,
   output logic [31:0]        root,
   output spnp_side_type      side_out
);

   localparam int unsigned STEPS  = 2;
   localparam int unsigned STAGES = 32 / STEPS;

   logic [STAGES-1:0] vld_ff;
   logic [63:0]       rad_ff  [STAGES];
   logic [34:0]       rem_ff  [STAGES];
   logic [31:0]       root_ff [STAGES];
   spnp_side_type     side_ff [STAGES];

   // Each stage retires STEPS restoring steps of the digit-by-digit root.
   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      logic              vld_src;
      logic [63:0]       rad_src;
      logic [34:0]       rem_src;
      logic [31:0]       root_src;
      spnp_side_type     side_src;
      logic [63:0]       rad_in;
      logic [34:0]       rem_in;
      logic [31:0]       root_in;

      if (g == 0) begin : g_first
         assign vld_src  = in_valid;
         assign rad_src  = radicand;
         assign rem_src  = '0;
         assign root_src = '0;
         assign side_src = side_in;
      end else begin : g_next
         assign vld_src  = vld_ff[g-1];
         assign rad_src  = rad_ff[g-1];
         assign rem_src  = rem_ff[g-1];
         assign root_src = root_ff[g-1];
         assign side_src = side_ff[g-1];
      end

      always_comb begin
         logic [34:0] trial;
         rad_in  = rad_src;
         rem_in  = rem_src;
         root_in = root_src;
         for (int k = 0; k < STEPS; k++) begin
            rem_in = {rem_in[32:0], rad_in[63:62]};
            trial  = {1'b0, root_in, 2'b01};
            if (rem_in >= trial) begin
               rem_in  = rem_in - trial;
               root_in = {root_in[30:0], 1'b1};
            end else begin
               root_in = {root_in[30:0], 1'b0};
            end
            rad_in = {rad_in[61:0], 2'b00};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else begin
            vld_ff[g] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[g]  <= rad_in;
         rem_ff[g]  <= rem_in;
         root_ff[g] <= root_in;
         side_ff[g] <= side_src;
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign root      = root_ff[STAGES-1];
   assign side_out  = side_ff[STAGES-1];

endmodule : spnp_isqrt

`default_nettype wire

>>> rtl/core/spnp_back.sv
// Back end of the mapper: polar edge indices from the square root,
// selection between belt and caps, and bit interleaving into the index.
// Depends on spnp_pkg.
`default_nettype none

module spnp_back
   import spnp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [ORDER_W-1:0] order,
   input  wire logic               in_valid,
   input  wire logic [31:0]        root,
   input  spnp_side_type           side,
   output logic                    out_valid,
   output logic [PIX_W-1:0]        pixel_number
);

   // Stage 1: fractional sector position times the scaled root.
   logic               b1_valid_ff;
   logic [63:0]        b1_prod_ff;
   logic [31:0]        b1_root_ff;
   spnp_side_type      b1_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      b1_prod_ff <= side.tp * root;
      b1_root_ff <= root;
      b1_side_ff <= side;
   end

   // Stage 2: polar edge indices and the choice of face, x and y.
   // The product stays below 2^64, so neither edge index can reach nside.
   logic [63:0]        jm_full;
   logic [ORDER_W-1:0] drop2;
   logic [EDGE_W-1:0]  mask2, jp2, jm2;
   logic [FACE_W-1:0]  face2_in;
   logic [EDGE_W-1:0]  ix2_in, iy2_in;

   logic               b2_valid_ff;
   logic [FACE_W-1:0]  b2_face_ff;
   logic [EDGE_W-1:0]  b2_ix_ff, b2_iy_ff;

   always_comb begin
      jm_full = {b1_root_ff, 32'd0} - b1_prod_ff;
      drop2   = ORDER_W'(EDGE_W) - order;
      mask2   = (EDGE_W'(1) << order) - EDGE_W'(1);
      jp2     = b1_prod_ff[63 -: EDGE_W] >> drop2;
      jm2     = jm_full[63 -: EDGE_W] >> drop2;
      if (b1_side_ff.belt) begin
         face2_in = b1_side_ff.face;
         ix2_in   = b1_side_ff.ix;
         iy2_in   = b1_side_ff.iy;
      end else if (b1_side_ff.north) begin
         face2_in = FACE_W'(b1_side_ff.ntt);
         ix2_in   = jm2 ^ mask2;
         iy2_in   = jp2 ^ mask2;
      end else begin
         face2_in = FACE_W'(b1_side_ff.ntt) + FACE_W'(8);
         ix2_in   = jp2;
         iy2_in   = jm2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_valid_ff <= 1'b0;
      end else begin
         b2_valid_ff <= b1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b2_face_ff <= face2_in;
      b2_ix_ff   <= ix2_in;
      b2_iy_ff   <= iy2_in;
   end

   // Stage 3: x on even bits, y on odd bits, face above them.
   logic [PIX_W-1:0] inter3;
   logic [PIX_W-1:0] pixel_in;

   always_comb begin
      inter3 = '0;
      for (int b = 0; b < EDGE_W; b++) begin
         inter3[2*b]   = b2_ix_ff[b];
         inter3[2*b+1] = b2_iy_ff[b];
      end
      pixel_in = (PIX_W'(b2_face_ff) << {order, 1'b0}) + inter3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else begin
         out_valid <= b2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      pixel_number <= pixel_in;
   end

endmodule : spnp_back

`default_nettype wire

>>> rtl/core/sphere_point_to_nested_pixel_top.sv
// Sphere point to nested HEALPix pixel mapper, top level.
// Depends on spnp_pkg, spnp_front, spnp_isqrt and spnp_back.
//
// A beat on start carries z = cos(theta) in Q2.30 and the longitude phi in
// Q4.28 radians; rsp_strobe later goes high for one cycle with the nested
// pixel number at nside = 2^order. The pipeline takes a new beat on every
// clock, so busy stays low and results leave in the order the points
// arrived, one per clock at most. The pipeline is the 32-step cap square
// root, retired two steps per stage over sixteen stages, plus three
// front-end and three back-end stages. The receiver cannot stall the
// result. Orders above MAX_ORDER are stored as MAX_ORDER; write the order
// only while no points are in flight.
`default_nettype none

module sphere_point_to_nested_pixel_top
   import spnp_pkg::*;
#(
   parameter int unsigned MAX_ORDER = MAX_ORDER_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [31:0] req_z_cos_theta,
   input  wire logic signed [31:0] req_phi_radians,
   output logic                    rsp_strobe,
   output logic [PIX_W-1:0]        rsp_pixel_number,
   input  wire logic               csr_write_enable,
   input  wire logic [ORDER_W-1:0] csr_write_data
);

   localparam logic [ORDER_W-1:0] ORDER_LIMIT = ORDER_W'(MAX_ORDER);

   // Resolution order register, saturated on write.
   logic [ORDER_W-1:0] order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= '0;
      end else if (csr_write_enable) begin
         order_ff <= (csr_write_data > ORDER_LIMIT) ? ORDER_LIMIT : csr_write_data;
      end
   end

   // The pipeline never holds off a beat.
   assign busy = 1'b0;

   logic          front_valid;
   logic [63:0]   front_radicand;
   spnp_side_type front_side;
   logic          sqrt_valid;
   logic [31:0]   sqrt_root;
   spnp_side_type sqrt_side;

   spnp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .order       (order_ff),
      .in_valid    (start && !busy),
      .z_cos_theta (req_z_cos_theta),
      .phi_radians (req_phi_radians),
      .out_valid   (front_valid),
      .radicand    (front_radicand),
      .side        (front_side)
   );

   spnp_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .radicand  (front_radicand),
      .side_in   (front_side),
      .out_valid (sqrt_valid),
      .root      (sqrt_root),
      .side_out  (sqrt_side)
   );

   spnp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .order        (order_ff),
      .in_valid     (sqrt_valid),
      .root         (sqrt_root),
      .side         (sqrt_side),
      .out_valid    (rsp_strobe),
      .pixel_number (rsp_pixel_number)
   );

`ifndef SYNTHESIS
   // The stored order never exceeds the configured limit.
   assert property (@(posedge clock) disable iff (reset) order_ff <= ORDER_LIMIT)
      else $error("resolution order above limit");

   // A delivered pixel lies on one of the twelve base faces.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_pixel_number >> {order_ff, 1'b0}) < PIX_W'(12)))
      else $error("pixel number beyond the twelve faces");

   // A point offered on start is never refused through busy.
   assert property (@(posedge clock) disable iff (reset) start |-> !busy)
      else $error("start refused");
`endif

endmodule : sphere_point_to_nested_pixel_top

`default_nettype wire

>>> sim/sphere_point_to_nested_pixel_top_tb.sv
// Self-checking testbench for the sphere-point to nested-pixel mapper.
// Depends on spnp_pkg and sphere_point_to_nested_pixel_top; it predicts each pixel
// number itself and checks every strobed beat, across several resolution orders.
`default_nettype none

module sphere_point_to_nested_pixel_top_tb
   import spnp_pkg::*;
();

   localparam int unsigned TOP_ORDER = MAX_ORDER_DEFAULT;
   localparam int          PIPE_CYCLES = 22;
   localparam logic signed [31:0] Z_ONE = 32'sd1073741824;
   localparam logic signed [31:0] Z_BELT = 32'sd715827882;
   localparam logic signed [31:0] PHI_2PI = 32'sd1686629713;
   localparam logic signed [31:0] PHI_PI_2 = 32'sd421657428;

   typedef struct {
      logic signed [31:0] z;
      logic signed [31:0] phi;
      bit                 typed;
      logic [PIX_W-1:0]   pixel;
   } point_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic signed [31:0]      req_z_cos_theta = '0;
   logic signed [31:0]      req_phi_radians = '0;
   logic                    rsp_strobe;
   logic [PIX_W-1:0]        rsp_pixel_number;
   logic                    csr_write_enable = 1'b0;
   logic [ORDER_W-1:0]      csr_write_data = '0;

   logic [ORDER_W-1:0]      order_shadow = '0;
   logic [PIX_W-1:0]        pixel_queue[$];
   int unsigned             mismatches = 0;
   bit                      quiet_stretch = 1'b0;

   sphere_point_to_nested_pixel_top #(.MAX_ORDER(TOP_ORDER)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_z_cos_theta(req_z_cos_theta), .req_phi_radians(req_phi_radians),
      .rsp_strobe(rsp_strobe), .rsp_pixel_number(rsp_pixel_number),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Integer square root, bit by bit.
   function automatic logic [63:0] root64(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Nested pixel number of one point at the given order.
   function automatic logic [PIX_W-1:0] nested_pixel(input logic [ORDER_W-1:0] ord_in,
                                                     input logic signed [31:0] z_in,
                                                     input logic signed [31:0] phi_in);
      int unsigned ord;
      longint      nside, z, p, za, zs, a, jp_b, jm_b, ifp, ifm;
      logic [63:0] tt, face, ix, iy, ntt, tp, d, s, jp, jm, pix;
      ord   = (ord_in > TOP_ORDER) ? TOP_ORDER : ord_in;
      nside = longint'(1) << ord;
      z     = z_in;
      p     = phi_in;
      za    = (z < 0) ? -z : z;
      if (za > Z_ONE) za = Z_ONE;
      while (p < 0) p = p + PHI_2PI;
      while (p >= PHI_2PI) p = p - PHI_2PI;
      tt = (64'(p) * 64'd2734261102) >> 28;
      if (za <= Z_BELT) begin
         // Equatorial belt: edge-line indices.
         zs   = ((z < 0) ? -za : za) * 3;
         a    = longint'(64'd2147483648) + longint'(tt);
         jp_b = ((a - zs) <<< ord) >>> 32;
         jm_b = ((a + zs) <<< ord) >>> 32;
         ifp  = jp_b >>> ord;
         ifm  = jm_b >>> ord;
         if (ifp == ifm) face = (ifp == 4) ? 64'd4 : 64'(ifp + 4);
         else if (ifp < ifm) face = 64'(ifp);
         else face = 64'(ifm + 8);
         ix = 64'(jm_b & (nside - 1));
         iy = 64'(nside - (jp_b & (nside - 1)) - 1);
      end else begin
         // Polar cap: square root, then clamp both edge indices.
         ntt = tt >> 32;
         if (ntt > 3) ntt = 3;
         tp = tt - (ntt << 32);
         d  = 64'(longint'(Z_ONE) - za);
         s  = root64((64'd3 * d) << 34);
         jp = ((tp * s) >> 32) >> (32 - ord);
         jm = (((64'd1 << 32) - tp) * s >> 32) >> (32 - ord);
         if (jp >= 64'(nside)) jp = 64'(nside) - 1;
         if (jm >= 64'(nside)) jm = 64'(nside) - 1;
         if (z >= 0) begin
            face = ntt;
            ix   = 64'(nside) - jm - 1;
            iy   = 64'(nside) - jp - 1;
         end else begin
            face = ntt + 8;
            ix   = jp;
            iy   = jm;
         end
      end
      pix = face << (2 * ord);
      for (int b = 0; b < ord; b++) begin
         pix[2*b]   = pix[2*b] | ix[b];
         pix[2*b+1] = pix[2*b+1] | iy[b];
      end
      return pix[PIX_W-1:0];
   endfunction

   // Sample away from the driving edge: record accepted beats, check strobed results.
   always @(negedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pixel_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: pixel %0d", rsp_pixel_number);
         end else begin
            if (rsp_pixel_number !== pixel_queue[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("pixel mismatch: expected %0d, got %0d",
                           pixel_queue[0], rsp_pixel_number);
            end
            void'(pixel_queue.pop_front());
         end
      end
      if (!reset && start && !busy)
         pixel_queue = {pixel_queue,
                        nested_pixel(order_shadow, req_z_cos_theta, req_phi_radians)};
   end

   // Present one point, sometimes after a random gap, and hold it until taken.
   task automatic send_point(input logic signed [31:0] z, input logic signed [31:0] phi);
      bit taken;
      if (!quiet_stretch && $urandom_range(99) < 30) begin
         start <= 1'b0;
         repeat ($urandom_range(2, 1)) @(posedge clock);
      end
      start           <= 1'b1;
      req_z_cos_theta <= z;
      req_phi_radians <= phi;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
   endtask

   // Let the pipeline drain, then write a new order.
   task automatic set_order(input logic [ORDER_W-1:0] ord);
      start <= 1'b0;
      @(posedge clock);
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (PIPE_CYCLES + 4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= ord;
      order_shadow     <= ord;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic signed [31:0] random_z();
      int unsigned pick;
      pick = $urandom_range(9);
      case (pick)
         0: return $urandom();
         1: return $urandom_range(1) ? Z_ONE : -Z_ONE;
         2: return (Z_BELT + $signed($urandom_range(4)) - 2) * ($urandom_range(1) ? 1 : -1);
         3, 4: return $signed($urandom_range(1073741824, 715827883))
                      * ($urandom_range(1) ? 1 : -1);
         default: return $signed($urandom_range(1431655764)) - Z_BELT;
      endcase
   endfunction

   function automatic logic signed [31:0] random_phi();
      case ($urandom_range(3))
         0: return $urandom();
         1: return PHI_PI_2 * $signed($urandom_range(4)) + $signed($urandom_range(4)) - 2;
         default: return $signed($urandom_range(1686629712));
      endcase
   endfunction

   point_row_type directed_rows [17] = '{
      '{Z_ONE, 32'sd0, 1'b1, 30'd0},
      '{-Z_ONE, 32'sd0, 1'b1, 30'd8},
      '{32'sd0, 32'sd0, 1'b0, 30'd0},
      '{Z_BELT, 32'sd100000000, 1'b0, 30'd0},
      '{Z_BELT + 1, 32'sd100000000, 1'b0, 30'd0},
      '{-Z_BELT, 32'sd500000000, 1'b0, 30'd0},
      '{-Z_BELT - 1, 32'sd500000000, 1'b0, 30'd0},
      '{32'sh7fffffff, 32'sh7fffffff, 1'b0, 30'd0},
      '{32'sh80000000, 32'sh80000000, 1'b0, 30'd0},
      '{32'sd5, PHI_2PI - 1, 1'b0, 30'd0},
      '{32'sd5, PHI_2PI, 1'b0, 30'd0},
      '{-32'sd5, -32'sd1, 1'b0, 30'd0},
      '{32'sd900000000, PHI_2PI - 1, 1'b0, 30'd0},
      '{-32'sd900000000, PHI_PI_2 * 3, 1'b0, 30'd0},
      '{32'sd1073741823, PHI_PI_2, 1'b0, 30'd0},
      '{32'sd300000000, PHI_PI_2 * 2, 1'b0, 30'd0},
      '{-32'sd300000000, 32'sd1, 1'b0, 30'd0}
   };

   logic [ORDER_W-1:0] order_plan [8] = '{4'd13, 4'd15, 4'd0, 4'd7, 4'd1, 4'd10, 4'd3, 4'd13};

   // Main sequence: directed rows at the reset order, then random phases.
   initial begin
      logic [PIX_W-1:0] row_pixel;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) begin
         send_point(directed_rows[i].z, directed_rows[i].phi);
         row_pixel = nested_pixel(order_shadow, directed_rows[i].z, directed_rows[i].phi);
         if (directed_rows[i].typed && row_pixel !== directed_rows[i].pixel) begin
            mismatches++;
            if (mismatches <= 10)
               $display("pole row %0d: expected %0d, got %0d",
                        i, directed_rows[i].pixel, row_pixel);
         end
      end
      foreach (order_plan[k]) begin
         set_order(order_plan[k]);
         for (int n = 0; n < 105; n++) begin
            quiet_stretch = (k == 3) && (n >= 20) && (n < 90);
            send_point(random_z(), random_phi());
         end
      end
      start <= 1'b0;
      @(posedge clock);
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (PIPE_CYCLES + 8) @(posedge clock);
      if (mismatches == 0 && pixel_queue.size() == 0)
         $display("PASS sphere_point_to_nested_pixel_top");
      else
         $display("FAIL sphere_point_to_nested_pixel_top");
      $finish;
   end

   // Watchdog.
   initial begin
      #2000000;
      $display("FAIL sphere_point_to_nested_pixel_top");
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/spnp_pkg.sv
rtl/core/spnp_front.sv
rtl/core/spnp_isqrt.sv
rtl/core/spnp_back.sv
rtl/core/sphere_point_to_nested_pixel_top.sv
sim/sphere_point_to_nested_pixel_top_tb.sv
